/* hw/rtl/vfv_pkg.sv */
// Package for the voxel face visibility block: sizes, field structs, codes, FSM states.
// No dependencies; imported by vfv_engine, voxel_face_visibility_top and vfv_checker.
`timescale 1ns / 1ps
`default_nettype none

package vfv_pkg;

  localparam int unsigned MAX_WIDTH    = 16;
  localparam int unsigned MAX_HEIGHT   = 64;

  localparam int unsigned POS_XZ_W     = 4;
  localparam int unsigned POS_Y_W      = 6;
  localparam int unsigned KIND_W       = 4;
  localparam int unsigned WIDTH_REG_W  = 5;
  localparam int unsigned HEIGHT_REG_W = 7;
  localparam int unsigned FACES        = 6;
  localparam int unsigned COUNT_W      = 3;
  localparam int unsigned FACE_IDX_W   = 3;

  localparam int unsigned STORE_CELLS  = MAX_HEIGHT * MAX_WIDTH * MAX_WIDTH;
  localparam int unsigned ADDR_W       = $clog2(STORE_CELLS);

  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned S_TDATA_W    = 24;
  localparam int unsigned M_TDATA_W    = 16;

  localparam logic [KIND_W-1:0] KIND_AIR  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_DIRT = 4'd1;

  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  // neighbor order, also the face_mask bit order
  localparam logic [FACE_IDX_W-1:0] FACE_DOWN  = 3'd0;
  localparam logic [FACE_IDX_W-1:0] FACE_UP    = 3'd1;
  localparam logic [FACE_IDX_W-1:0] FACE_FRONT = 3'd2;
  localparam logic [FACE_IDX_W-1:0] FACE_BACK  = 3'd3;
  localparam logic [FACE_IDX_W-1:0] FACE_RIGHT = 3'd4;
  localparam logic [FACE_IDX_W-1:0] FACE_LEFT  = 3'd5;

  typedef struct packed {
    logic                action;
    logic [POS_XZ_W-1:0] pos_x;
    logic [POS_Y_W-1:0]  pos_y;
    logic [POS_XZ_W-1:0] pos_z;
    logic [KIND_W-1:0]   block_kind;
  } item_t;

  typedef struct packed {
    logic [FACES-1:0]   face_mask;
    logic [COUNT_W-1:0] face_count;
    logic               out_of_range;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/vfv_engine.sv */
// Block store (single-port synchronous RAM) with its sequencer: clearing pass,
// cell writes and six neighbor reads per query. Depends on vfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfv_engine (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              item_valid_i,
  output logic                                   item_ready_o,
  input  wire vfv_pkg::item_t                    item_i,
  input  wire logic [vfv_pkg::WIDTH_REG_W-1:0]   width_i,
  input  wire logic [vfv_pkg::HEIGHT_REG_W-1:0]  height_i,
  output logic                                   res_valid_o,
  input  wire logic                              res_ready_i,
  output vfv_pkg::result_t                       res_o
);
  import vfv_pkg::*;

  state_e                  state_q, state_d;
  logic [POS_XZ_W-1:0]     x_q, z_q;
  logic [POS_Y_W-1:0]      y_q;
  logic [KIND_W-1:0]       kind_q;
  logic                    oor_q, oor_d;
  logic [FACES-1:0]        mask_q, mask_d;
  logic [FACE_IDX_W-1:0]   k_q, k_d;
  logic                    rd_pend_q;
  logic [FACE_IDX_W-1:0]   rd_idx_q;
  logic [ADDR_W-1:0]       clr_q, clr_d;

  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic [KIND_W-1:0]       mem_wdata;
  logic [KIND_W-1:0]       mem_q [STORE_CELLS];
  logic [KIND_W-1:0]       rd_data_q;

  logic                    accept;
  logic                    in_oor;
  logic [FACES-1:0]        bnd;
  logic [ADDR_W-1:0]       nbr_addr;
  logic [COUNT_W-1:0]      count;

  assign accept = item_valid_i && item_ready_o;

  // range check and boundary faces of the incoming item
  always_comb begin
    in_oor = ({1'b0, item_i.pos_x} >= width_i) || ({1'b0, item_i.pos_z} >= width_i)
          || ({1'b0, item_i.pos_y} >= height_i);
    bnd = '0;
    bnd[FACE_DOWN]  = (HEIGHT_REG_W'(item_i.pos_y) + 1'b1) >= height_i;
    bnd[FACE_UP]    = item_i.pos_y == '0;
    bnd[FACE_FRONT] = (WIDTH_REG_W'(item_i.pos_z) + 1'b1) >= width_i;
    bnd[FACE_BACK]  = item_i.pos_z == '0;
    bnd[FACE_RIGHT] = (WIDTH_REG_W'(item_i.pos_x) + 1'b1) >= width_i;
    bnd[FACE_LEFT]  = item_i.pos_x == '0;
  end

  // neighbor address; wrapped values at the edges are read but masked by bnd
  always_comb begin
    case (k_q)
      FACE_DOWN:  nbr_addr = {y_q + 1'b1, z_q, x_q};
      FACE_UP:    nbr_addr = {y_q - 1'b1, z_q, x_q};
      FACE_FRONT: nbr_addr = {y_q, z_q + 1'b1, x_q};
      FACE_BACK:  nbr_addr = {y_q, z_q - 1'b1, x_q};
      FACE_RIGHT: nbr_addr = {y_q, z_q, x_q + 1'b1};
      FACE_LEFT:  nbr_addr = {y_q, z_q, x_q - 1'b1};
      default:    nbr_addr = {y_q, z_q, x_q};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(STORE_CELLS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (item_valid_i) begin
          if (in_oor) state_d = ST_DONE;
          else if (item_i.action == ACT_WRITE) state_d = ST_WRITE;
          else state_d = ST_READ;
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_READ:  if (k_q == FACE_LEFT) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = nbr_addr;
    mem_wdata    = kind_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = (clr_q[ADDR_W-1 -: POS_Y_W] == POS_Y_W'(1)) ? KIND_AIR : KIND_DIRT;
      end
      ST_IDLE:  item_ready_o = 1'b1;
      ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = {y_q, z_q, x_q};
      end
      ST_READ:  mem_addr = nbr_addr;
      ST_DRAIN: mem_addr = nbr_addr;
      ST_DONE:  res_valid_o = 1'b1;
      default:  item_ready_o = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    clr_d  = (state_q == ST_CLEAR) ? clr_q + 1'b1 : clr_q;
    k_d    = (state_q == ST_READ) ? k_q + 1'b1 : '0;
    oor_d  = accept ? in_oor : oor_q;
    mask_d = mask_q;
    if (rd_pend_q && rd_data_q == KIND_AIR) mask_d[rd_idx_q] = 1'b1;
    if (accept) mask_d = (in_oor || item_i.action == ACT_WRITE) ? '0 : bnd;
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < FACES; i++) count = count + COUNT_W'(mask_q[i]);
  end

  assign res_o = '{face_mask: mask_q, face_count: count, out_of_range: oor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      k_q       <= k_d;
      rd_pend_q <= (state_q == ST_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= k_q;
    mask_q   <= mask_d;
    oor_q    <= oor_d;
    if (accept) begin
      x_q    <= item_i.pos_x;
      y_q    <= item_i.pos_y;
      z_q    <= item_i.pos_z;
      kind_q <= item_i.block_kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rd_data_q <= mem_q[mem_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/voxel_face_visibility_top.sv */
// Top level: stream ports, extent registers, output register; instantiates vfv_engine.
// Depends on vfv_pkg.
// A query passes ST_READ (one neighbor read per face), ST_DRAIN, ST_DONE and the output register;
// a write passes ST_WRITE, ST_DONE and the output register; out-of-range goes straight to ST_DONE.
// One item at a time: the next input transfer waits until the sequencer is back in ST_IDLE; stalls add.
// After reset a clearing pass over all 16384 cells fills the store (input not ready, config taken).
`timescale 1ns / 1ps
`default_nettype none

module voxel_face_visibility_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pos_x[3:0], pos_y[9:4], pos_z[13:10], block_kind[17:14], zero pad
  input  wire logic [vfv_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // action
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // face_mask[5:0], face_count[8:6], zero pad
  output logic [vfv_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // out_of_range
  output logic                                   m_axis_tuser,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [vfv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [vfv_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import vfv_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_q, width_d;
  logic [HEIGHT_REG_W-1:0] height_q, height_d;
  logic [WIDTH_REG_W-1:0]  width_eff;
  logic [HEIGHT_REG_W-1:0] height_eff;
  item_t                   item;
  result_t                 res;
  logic                    res_valid, res_ready;
  logic                    out_valid_q;
  result_t                 out_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_d  = cfg_data_i[WIDTH_REG_W-1:0];
        CFG_HEIGHT: height_d = cfg_data_i[HEIGHT_REG_W-1:0];
        default:    width_d  = width_q;
      endcase
    end
  end

  assign width_eff  = (width_q > WIDTH_REG_W'(MAX_WIDTH)) ? WIDTH_REG_W'(MAX_WIDTH) : width_q;
  assign height_eff = (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) ?
                      HEIGHT_REG_W'(MAX_HEIGHT) : height_q;

  assign item = '{
    action:     s_axis_tuser,
    pos_x:      s_axis_tdata[3:0],
    pos_y:      s_axis_tdata[9:4],
    pos_z:      s_axis_tdata[13:10],
    block_kind: s_axis_tdata[17:14]
  };

  assign res_ready = !out_valid_q || m_axis_tready;

  vfv_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_REG_W'(MAX_WIDTH);
      height_q    <= HEIGHT_REG_W'(MAX_HEIGHT);
      out_valid_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      if (res_ready) out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - FACES - COUNT_W)'(0), out_q.face_count, out_q.face_mask};
  assign m_axis_tuser  = out_q.out_of_range;

endmodule

`default_nettype wire

/* hw/rtl/vfv_checker.sv */
// Port-level checks for voxel_face_visibility_top, bound to it below.
// Depends on vfv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfv_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [vfv_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                            s_axis_tuser,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [vfv_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  wire logic                            m_axis_tuser,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_o,
  input  wire logic [vfv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [vfv_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import vfv_pkg::*;

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && !s_axis_tready)
    else $error("outputs active during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[FACES+COUNT_W-1:FACES] ==
    COUNT_W'($countones(m_axis_tdata[FACES-1:0])))
    else $error("face_count does not match face_mask");

  a_oor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[FACES-1:0] == '0)
    else $error("out-of-range result carries faces");

endmodule

bind voxel_face_visibility_top vfv_checker u_vfv_checker (.*);

`default_nettype wire

/* sim/vfv_face_checker.sv */
`timescale 1ns / 1ps
// Checker for voxel_face_visibility_top: watches the register, input and result channels.
// Predicts visible-face results from its own copy of the chunk store and compares them.
// Depends on vfv_pkg.

module vfv_face_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // pos_x[3:0], pos_y[9:4], pos_z[13:10], block_kind[17:14], zero pad
  input  logic [vfv_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // face_mask[5:0], face_count[8:6], zero pad
  input  logic [vfv_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // out_of_range
  input  logic                           m_axis_tuser,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [vfv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vfv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import vfv_pkg::*;

  logic [KIND_W-1:0]       cells [STORE_CELLS];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  result_t                 faces_q [$];
  int                      fails;

  function automatic logic is_air(int x, int y, int z);
    int idx;
    idx = (y * int'(MAX_WIDTH) + z) * int'(MAX_WIDTH) + x;
    if (idx < 0 || idx >= int'(STORE_CELLS)) return 1'b1;
    return cells[idx] == KIND_AIR;
  endfunction

  function automatic result_t predict_faces(item_t it);
    int      w;
    int      h;
    int      x;
    int      y;
    int      z;
    result_t r;
    w = (width_reg > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(width_reg);
    h = (height_reg > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(height_reg);
    x = int'(it.pos_x);
    y = int'(it.pos_y);
    z = int'(it.pos_z);
    r = '0;
    r.out_of_range = (x >= w) || (z >= w) || (y >= h);
    if (!r.out_of_range) begin
      if (it.action == ACT_WRITE) begin
        cells[(y * int'(MAX_WIDTH) + z) * int'(MAX_WIDTH) + x] = it.block_kind;
      end else begin
        r.face_mask[FACE_DOWN]  = (y + 1 >= h) || is_air(x, y + 1, z);
        r.face_mask[FACE_UP]    = (y == 0) || is_air(x, y - 1, z);
        r.face_mask[FACE_FRONT] = (z + 1 >= w) || is_air(x, y, z + 1);
        r.face_mask[FACE_BACK]  = (z == 0) || is_air(x, y, z - 1);
        r.face_mask[FACE_RIGHT] = (x + 1 >= w) || is_air(x + 1, y, z);
        r.face_mask[FACE_LEFT]  = (x == 0) || is_air(x - 1, y, z);
      end
    end
    r.face_count = COUNT_W'($countones(r.face_mask));
    return r;
  endfunction

  always @(posedge clk_i) begin
    item_t   it;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < int'(STORE_CELLS); i++) begin
        cells[i] = (i / int'(MAX_WIDTH * MAX_WIDTH) == 1) ? KIND_AIR : KIND_DIRT;
      end
      width_reg  = WIDTH_REG_W'(MAX_WIDTH);
      height_reg = HEIGHT_REG_W'(MAX_HEIGHT);
      faces_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WIDTH) begin
          width_reg = cfg_data_i[WIDTH_REG_W-1:0];
        end else if (cfg_index_i == CFG_HEIGHT) begin
          height_reg = cfg_data_i[HEIGHT_REG_W-1:0];
        end
      end
      // results before new items: a result never belongs to an item taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.face_mask    = m_axis_tdata[FACES-1:0];
        got.face_count   = m_axis_tdata[FACES+COUNT_W-1:FACES];
        got.out_of_range = m_axis_tuser;
        if (faces_q.size() == 0) begin
          $error("result transfer with nothing expected: mask %h count %0d oor %0b",
                 got.face_mask, got.face_count, got.out_of_range);
          fails++;
        end else begin
          want = faces_q.pop_front();
          if (got.face_mask !== want.face_mask) begin
            $error("face_mask: expected %h, got %h", want.face_mask, got.face_mask);
            fails++;
          end
          if (got.face_count !== want.face_count) begin
            $error("face_count: expected %0d, got %0d", want.face_count, got.face_count);
            fails++;
          end
          if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                   got.out_of_range);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.action     = s_axis_tuser;
        it.pos_x      = s_axis_tdata[3:0];
        it.pos_y      = s_axis_tdata[9:4];
        it.pos_z      = s_axis_tdata[13:10];
        it.block_kind = s_axis_tdata[17:14];
        faces_q = {faces_q, predict_faces(it)};
      end
    end
    fail_count_o <= fails;
    pending_o    <= faces_q.size();
  end

endmodule

/* sim/voxel_face_visibility_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for voxel_face_visibility_top: clock, reset, extent writes and item stimulus.
// Depends on vfv_pkg, voxel_face_visibility_top and vfv_face_checker.

module voxel_face_visibility_top_tb;
  import vfv_pkg::*;

  localparam int unsigned PHASES     = 7;
  localparam int unsigned PHASE_ITEMS = 250;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int          fail_count;
  int          pending;
  int unsigned tx_max = 0;
  int unsigned rx_max = 0;
  int unsigned cur_w  = MAX_WIDTH;
  int unsigned cur_h  = MAX_HEIGHT;
  int unsigned n_writes;
  int unsigned n_queries;
  int unsigned n_settings;

  voxel_face_visibility_top u_top (.*);

  vfv_face_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  always #10 clk_i = ~clk_i;

  task automatic send_item(input logic act, input int unsigned x, input int unsigned y,
                           input int unsigned z, input int unsigned kind);
    int unsigned          gap;
    logic [S_TDATA_W-1:0] word;
    gap         = $urandom_range(0, tx_max);
    word        = '0;
    word[3:0]   = x[3:0];
    word[9:4]   = y[5:0];
    word[13:10] = z[3:0];
    word[17:14] = kind[3:0];
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= word;
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    if (act == ACT_WRITE) n_writes++;
    else n_queries++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // upper data bits above each register's width are noise and must be dropped
  task automatic set_extents(input int unsigned w, input int unsigned h);
    logic [2:0] w_pad;
    logic       h_pad;
    w_pad = 3'($urandom);
    h_pad = 1'($urandom);
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= {w_pad, w[4:0]};
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= {h_pad, h[6:0]};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_w = (32'(w[4:0]) > MAX_WIDTH) ? MAX_WIDTH : 32'(w[4:0]);
    cur_h = (32'(h[6:0]) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(h[6:0]);
    n_settings++;
  endtask

  function automatic int unsigned pick_coord(int unsigned base, int unsigned extent,
                                             int unsigned top_val);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      v = base + $urandom_range(0, 3);
      return (v > top_val) ? top_val : v;
    end
    if (r < 9 && extent > 0) return $urandom_range(0, extent - 1);
    return $urandom_range(0, top_val);
  endfunction

  // result side
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned phase_w [5] = '{16, 31, 1, 2, 5};
    int unsigned phase_h [5] = '{64, 127, 2, 1, 9};
    int unsigned bx;
    int unsigned by;
    int unsigned bz;
    int unsigned kind;
    logic        act;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, neighbors of one carved cell, extent corners
    set_extents(16, 64);
    tx_max = 3;
    rx_max = 3;
    send_item(ACT_QUERY, 0, 0, 0, 0);
    send_item(ACT_QUERY, 15, 63, 15, 15);
    send_item(ACT_QUERY, 8, 2, 8, 0);
    send_item(ACT_QUERY, 8, 1, 8, 0);
    send_item(ACT_WRITE, 7, 10, 7, 32'(KIND_AIR));
    send_item(ACT_QUERY, 7, 11, 7, 0);
    send_item(ACT_QUERY, 7, 9, 7, 0);
    send_item(ACT_QUERY, 7, 10, 8, 0);
    send_item(ACT_QUERY, 7, 10, 6, 0);
    send_item(ACT_QUERY, 8, 10, 7, 0);
    send_item(ACT_QUERY, 6, 10, 7, 0);
    send_item(ACT_WRITE, 7, 10, 7, 15);
    send_item(ACT_QUERY, 7, 9, 7, 0);
    send_item(ACT_WRITE, 15, 63, 15, 32'(KIND_AIR));
    send_item(ACT_QUERY, 15, 62, 15, 0);
    drain();
    set_extents(1, 1);
    send_item(ACT_QUERY, 0, 0, 0, 0);
    send_item(ACT_QUERY, 1, 0, 0, 0);
    send_item(ACT_WRITE, 0, 5, 0, 32'(KIND_AIR));
    drain();
    set_extents(0, 127);
    send_item(ACT_QUERY, 0, 0, 0, 0);
    send_item(ACT_WRITE, 0, 0, 0, 32'(KIND_AIR));
    drain();
    set_extents(31, 0);
    send_item(ACT_QUERY, 3, 3, 3, 0);
    drain();
    set_extents(16, 64);
    send_item(ACT_QUERY, 0, 4, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0);
    drain();

    // random: writes and queries clustered in a small window so they interact
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p < 5) set_extents(phase_w[p], phase_h[p]);
      else set_extents($urandom_range(0, 31), $urandom_range(0, 127));
      bx = $urandom_range(0, (cur_w > 4) ? cur_w - 4 : 0);
      by = $urandom_range(0, (cur_h > 4) ? cur_h - 4 : 0);
      bz = $urandom_range(0, (cur_w > 4) ? cur_w - 4 : 0);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) begin
          tx_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
          rx_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
        end
        act  = ($urandom_range(0, 99) < 35) ? ACT_WRITE : ACT_QUERY;
        kind = $urandom_range(0, 1) ? 32'(KIND_AIR) : $urandom_range(0, 15);
        send_item(act, pick_coord(bx, cur_w, MAX_WIDTH - 1),
                  pick_coord(by, cur_h, MAX_HEIGHT - 1),
                  pick_coord(bz, cur_w, MAX_WIDTH - 1), kind);
        if ($urandom_range(0, 59) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d writes and %0d queries under %0d extent settings", n_writes,
             n_queries, n_settings);
    if (fail_count == 0 && pending == 0) begin
      $display("[voxel_face_visibility_top] OK");
    end else begin
      $display("[voxel_face_visibility_top] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[voxel_face_visibility_top] ERROR");
    $finish;
  end

endmodule

/* voxel_face_visibility_top.f */
hw/rtl/vfv_pkg.sv
hw/rtl/vfv_engine.sv
hw/rtl/voxel_face_visibility_top.sv
hw/rtl/vfv_checker.sv
sim/vfv_face_checker.sv
sim/voxel_face_visibility_top_tb.sv
